// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/dmwc_pkg.sv =====
// Types and constants of the direct-mapped write-back cache tag block.
`default_nettype none

package dmwc_pkg;

    localparam int ADDR_W  = 32;
    localparam int OFF_W   = 5;
    localparam int BLOCK_W = 27;
    localparam int LINE_W  = 7;
    localparam int TAG_W   = 20;
    localparam int BYTES_W = 6;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_sts;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } t_entry;

endpackage

`default_nettype wire

// ===== hdl/direct_mapped_writeback_cache_tags_core.sv =====
// Top level of the direct-mapped write-back cache tag block.
// Direct-mapped, write-back, write-allocate tag and control logic: each input item (address,
// write flag) yields one result item with the address split, hit/miss, fetch, write-back,
// replacement and the tag the line held before. Tag, valid and dirty bits share one
// single-port-write, registered-read line store; after reset a clearing pass zeroes it,
// during which no item is accepted. Each item is first read from the line store, then
// decided and its line written back, and no new item is accepted until that decision is
// made. A finished result waits in the output register; the next item is still accepted
// while it waits, but that item's lookup holds until the waiting result is taken.
`default_nettype none

module direct_mapped_writeback_cache_tags_core #(
    parameter int LINE_COUNT  = 128,
    parameter int BLOCK_BYTES = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [dmwc_pkg::ADDR_W-1:0]  i_address,
    input  wire logic                         i_is_write,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [dmwc_pkg::OFF_W-1:0]        o_byte_offset,
    output logic [dmwc_pkg::BLOCK_W-1:0]      o_block_number,
    output logic [dmwc_pkg::LINE_W-1:0]       o_line_index,
    output logic [dmwc_pkg::TAG_W-1:0]        o_tag_value,
    output logic                              o_miss,
    output logic                              o_mem_read,
    output logic [dmwc_pkg::BYTES_W-1:0]      o_mem_read_bytes,
    output logic                              o_mem_write,
    output logic [dmwc_pkg::BYTES_W-1:0]      o_mem_write_bytes,
    output logic                              o_replacement,
    output logic [dmwc_pkg::TAG_W-1:0]        o_evicted_tag
);

    dmwc_pkg::t_cmd w_cmd;
    dmwc_pkg::t_sts w_sts;

    dmwc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    dmwc_dpath #(
        .LINE_COUNT  (LINE_COUNT),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_address         (i_address),
        .i_is_write        (i_is_write),
        .o_byte_offset     (o_byte_offset),
        .o_block_number    (o_block_number),
        .o_line_index      (o_line_index),
        .o_tag_value       (o_tag_value),
        .o_miss            (o_miss),
        .o_mem_read        (o_mem_read),
        .o_mem_read_bytes  (o_mem_read_bytes),
        .o_mem_write       (o_mem_write),
        .o_mem_write_bytes (o_mem_write_bytes),
        .o_replacement     (o_replacement),
        .o_evicted_tag     (o_evicted_tag)
    );

endmodule

`default_nettype wire

// ===== hdl/dmwc_dpath.sv =====
// Datapath: address split, line store, hit/miss decision and result register.
`default_nettype none

module dmwc_dpath #(
    parameter int LINE_COUNT  = 128,
    parameter int BLOCK_BYTES = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire dmwc_pkg::t_cmd               i_cmd,
    output dmwc_pkg::t_sts                    o_sts,
    input  wire logic [dmwc_pkg::ADDR_W-1:0]  i_address,
    input  wire logic                         i_is_write,
    output logic [dmwc_pkg::OFF_W-1:0]        o_byte_offset,
    output logic [dmwc_pkg::BLOCK_W-1:0]      o_block_number,
    output logic [dmwc_pkg::LINE_W-1:0]       o_line_index,
    output logic [dmwc_pkg::TAG_W-1:0]        o_tag_value,
    output logic                              o_miss,
    output logic                              o_mem_read,
    output logic [dmwc_pkg::BYTES_W-1:0]      o_mem_read_bytes,
    output logic                              o_mem_write,
    output logic [dmwc_pkg::BYTES_W-1:0]      o_mem_write_bytes,
    output logic                              o_replacement,
    output logic [dmwc_pkg::TAG_W-1:0]        o_evicted_tag
);

    localparam int BOFF_W = $clog2(BLOCK_BYTES);
    localparam int IDX_W  = $clog2(LINE_COUNT);
    localparam logic [dmwc_pkg::BYTES_W-1:0] XFER_BYTES =
        dmwc_pkg::BYTES_W'(BLOCK_BYTES % 64);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_COUNT - 1);

    dmwc_pkg::t_entry r_mem [LINE_COUNT];
    dmwc_pkg::t_entry r_rd_data;
    dmwc_pkg::t_entry w_wr_data;
    logic [IDX_W-1:0] r_clr_idx, n_clr_idx;
    logic [IDX_W-1:0] w_wr_idx;
    logic [IDX_W-1:0] w_in_line;
    logic [dmwc_pkg::ADDR_W-1:0] r_addr;
    logic                        r_wr;
    logic [dmwc_pkg::ADDR_W-1:0] w_block;
    logic [dmwc_pkg::ADDR_W-1:0] w_tag_full;
    logic [dmwc_pkg::ADDR_W-1:0] w_off_full;
    logic [dmwc_pkg::ADDR_W-1:0] w_line_full;
    logic [dmwc_pkg::TAG_W-1:0]  w_tag;
    logic [IDX_W-1:0]            w_line;
    logic                        w_miss, w_wback, w_repl;

    function automatic logic [dmwc_pkg::ADDR_W-1:0] i_address_shift(
        input logic [dmwc_pkg::ADDR_W-1:0] a
    );
        return a >> BOFF_W;
    endfunction

    assign w_in_line   = i_address[BOFF_W +: IDX_W];
    assign w_block     = i_address_shift(r_addr);
    assign w_tag_full  = w_block >> IDX_W;
    assign w_off_full  = r_addr & dmwc_pkg::ADDR_W'(BLOCK_BYTES - 1);
    assign w_line_full = w_block & dmwc_pkg::ADDR_W'(LINE_COUNT - 1);
    assign w_tag       = w_tag_full[dmwc_pkg::TAG_W-1:0];
    assign w_line      = r_addr[BOFF_W +: IDX_W];

    assign w_miss  = !r_rd_data.valid || (r_rd_data.tag != w_tag);
    assign w_wback = w_miss && r_rd_data.dirty;
    assign w_repl  = w_miss && r_rd_data.valid;

    // Clearing pass writes zeros; otherwise the looked-up line is refilled.
    always_comb begin
        if (i_cmd.clear) begin
            w_wr_idx  = r_clr_idx;
            w_wr_data = '0;
        end else begin
            w_wr_idx        = w_line;
            w_wr_data.valid = 1'b1;
            w_wr_data.dirty = (!w_miss && r_rd_data.dirty) || r_wr;
            w_wr_data.tag   = w_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear || i_cmd.commit) begin
            r_mem[w_wr_idx] <= w_wr_data;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[w_in_line];
        end
    end

    assign n_clr_idx     = r_clr_idx + IDX_W'(1);
    assign o_sts.clr_last = (r_clr_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= n_clr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr <= i_address;
            r_wr   <= i_is_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_byte_offset     <= w_off_full[dmwc_pkg::OFF_W-1:0];
            o_block_number    <= w_block[dmwc_pkg::BLOCK_W-1:0];
            o_line_index      <= w_line_full[dmwc_pkg::LINE_W-1:0];
            o_tag_value       <= w_tag;
            o_miss            <= w_miss;
            o_mem_read        <= w_miss;
            o_mem_read_bytes  <= w_miss ? XFER_BYTES : '0;
            o_mem_write       <= w_wback;
            o_mem_write_bytes <= w_wback ? XFER_BYTES : '0;
            o_replacement     <= w_repl;
            o_evicted_tag     <= r_rd_data.tag;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dmwc_ctrl.sv =====
// Controller: clearing pass, lookup sequencing and result handshake.
`default_nettype none
`include "assert_macros.svh"

module dmwc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  wire logic           i_stall,
    output dmwc_pkg::t_cmd      o_cmd,
    input  wire dmwc_pkg::t_sts i_sts
);

    dmwc_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_slot_free;

    // Result register may be reloaded when empty or being taken this cycle.
    assign w_slot_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dmwc_pkg::S_CLEAR:  if (i_sts.clr_last) n_state = dmwc_pkg::S_IDLE;
            dmwc_pkg::S_IDLE:   if (i_valid) n_state = dmwc_pkg::S_LOOKUP;
            dmwc_pkg::S_LOOKUP: if (w_slot_free) n_state = dmwc_pkg::S_IDLE;
            default:            n_state = dmwc_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            dmwc_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            dmwc_pkg::S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            dmwc_pkg::S_LOOKUP: begin
                o_cmd.commit = w_slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign n_out_valid = o_cmd.commit || (r_out_valid && i_stall);
    assign o_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmwc_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_CLK(a_no_overwrite, o_cmd.commit |-> !(r_out_valid && i_stall), "result overwritten while stalled")
    `ASSERT_CLK(a_accept_to_lookup, o_cmd.accept |=> (r_state == dmwc_pkg::S_LOOKUP), "accepted item not looked up")
    `ASSERT_CLK(a_clear_quiet, (r_state == dmwc_pkg::S_CLEAR) |-> (!r_out_valid && !o_cmd.accept), "activity during clearing pass")
    `ASSERT_ALWAYS(a_one_cmd, $onehot0({o_cmd.clear, o_cmd.accept, o_cmd.commit}), "conflicting datapath commands")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for the direct-mapped write-back cache tag block.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINES       = 128;
    localparam int BLOCK_BYTES = 32;
    localparam int RANDOM_REFS = 800;

    typedef struct {
        logic [dmwc_pkg::ADDR_W-1:0] addr;
        logic                        wr;
    } t_mem_ref;

    typedef struct {
        logic [dmwc_pkg::OFF_W-1:0]   offset;
        logic [dmwc_pkg::BLOCK_W-1:0] block;
        logic [dmwc_pkg::LINE_W-1:0]  line;
        logic [dmwc_pkg::TAG_W-1:0]   tag;
        logic                         miss;
        logic                         mem_read;
        logic [dmwc_pkg::BYTES_W-1:0] read_bytes;
        logic                         mem_write;
        logic [dmwc_pkg::BYTES_W-1:0] write_bytes;
        logic                         replacement;
        logic [dmwc_pkg::TAG_W-1:0]   evicted;
    } t_lookup;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic [dmwc_pkg::ADDR_W-1:0]   i_address = '0;
    logic                          i_is_write = 1'b0;
    logic                          i_stall = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    logic [dmwc_pkg::OFF_W-1:0]    o_byte_offset;
    logic [dmwc_pkg::BLOCK_W-1:0]  o_block_number;
    logic [dmwc_pkg::LINE_W-1:0]   o_line_index;
    logic [dmwc_pkg::TAG_W-1:0]    o_tag_value;
    logic                          o_miss;
    logic                          o_mem_read;
    logic [dmwc_pkg::BYTES_W-1:0]  o_mem_read_bytes;
    logic                          o_mem_write;
    logic [dmwc_pkg::BYTES_W-1:0]  o_mem_write_bytes;
    logic                          o_replacement;
    logic [dmwc_pkg::TAG_W-1:0]    o_evicted_tag;

    direct_mapped_writeback_cache_tags_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_address         (i_address),
        .i_is_write        (i_is_write),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_byte_offset     (o_byte_offset),
        .o_block_number    (o_block_number),
        .o_line_index      (o_line_index),
        .o_tag_value       (o_tag_value),
        .o_miss            (o_miss),
        .o_mem_read        (o_mem_read),
        .o_mem_read_bytes  (o_mem_read_bytes),
        .o_mem_write       (o_mem_write),
        .o_mem_write_bytes (o_mem_write_bytes),
        .o_replacement     (o_replacement),
        .o_evicted_tag     (o_evicted_tag)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // shadow copy of the line store
    logic [dmwc_pkg::TAG_W-1:0] shadow_tag   [LINES];
    logic                       shadow_valid [LINES];
    logic                       shadow_dirty [LINES];

    t_mem_ref pending_refs[$];
    t_lookup  expected_lookups[$];

    int n_sent   = 0;
    int n_seen   = 0;
    int n_hits   = 0;
    int n_misses = 0;
    int n_wbacks = 0;
    int n_repls  = 0;
    int errors   = 0;

    // idle pattern changes every hundred items: none, sender, receiver, both lightly
    function automatic int idle_phase();
        return (n_sent / 100) % 4;
    endfunction

    function automatic bit sender_idles();
        case (idle_phase())
            1: return $urandom_range(99) < 76;
            3: return $urandom_range(99) < 6;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_phase())
            2: return $urandom_range(99) < 76;
            3: return $urandom_range(99) < 6;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void predict_lookup(input logic [dmwc_pkg::ADDR_W-1:0] addr,
                                           input logic wr);
        t_lookup r;
        logic    was_valid;
        logic    was_dirty;
        r.offset      = addr[dmwc_pkg::OFF_W-1:0];
        r.block       = addr[dmwc_pkg::ADDR_W-1:dmwc_pkg::OFF_W];
        r.line        = r.block[dmwc_pkg::LINE_W-1:0];
        r.tag         = r.block[dmwc_pkg::BLOCK_W-1:dmwc_pkg::LINE_W];
        was_valid     = shadow_valid[r.line];
        was_dirty     = shadow_dirty[r.line];
        r.evicted     = shadow_tag[r.line];
        r.miss        = !was_valid || (r.evicted != r.tag);
        r.mem_read    = r.miss;
        r.read_bytes  = r.miss ? dmwc_pkg::BYTES_W'(BLOCK_BYTES) : '0;
        r.mem_write   = r.miss && was_dirty;
        r.write_bytes = r.mem_write ? dmwc_pkg::BYTES_W'(BLOCK_BYTES) : '0;
        r.replacement = r.miss && was_valid;
        shadow_tag[r.line]   = r.tag;
        shadow_valid[r.line] = 1'b1;
        shadow_dirty[r.line] = (!r.miss && was_dirty) || wr;
        expected_lookups.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void add_ref(input logic [dmwc_pkg::ADDR_W-1:0] addr, input logic wr);
        t_mem_ref m;
        m.addr = addr;
        m.wr   = wr;
        pending_refs.push_back(m);
    endfunction

    // driver
    always @(posedge i_clk) begin : driver
        t_mem_ref nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_lookup(i_address, i_is_write);
                n_sent++;
            end
            if (!(i_valid && o_stall)) begin
                if (pending_refs.size() > 0 && !sender_idles()) begin
                    nxt = pending_refs.pop_front();
                    i_valid    <= 1'b1;
                    i_address  <= nxt.addr;
                    i_is_write <= nxt.wr;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_lookup e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_lookups.size() == 0) begin
                    $display("%0t: result item with nothing expected, line %0h tag %0h",
                             $time, o_line_index, o_tag_value);
                    errors++;
                end else begin
                    e = expected_lookups.pop_front();
                    n_seen++;
                    if (e.miss) n_misses++; else n_hits++;
                    if (e.mem_write) n_wbacks++;
                    if (e.replacement) n_repls++;
                    check_field("byte_offset", 32'(e.offset), 32'(o_byte_offset));
                    check_field("block_number", 32'(e.block), 32'(o_block_number));
                    check_field("line_index", 32'(e.line), 32'(o_line_index));
                    check_field("tag_value", 32'(e.tag), 32'(o_tag_value));
                    check_field("miss", 32'(e.miss), 32'(o_miss));
                    check_field("mem_read", 32'(e.mem_read), 32'(o_mem_read));
                    check_field("mem_read_bytes", 32'(e.read_bytes), 32'(o_mem_read_bytes));
                    check_field("mem_write", 32'(e.mem_write), 32'(o_mem_write));
                    check_field("mem_write_bytes", 32'(e.write_bytes),
                                32'(o_mem_write_bytes));
                    check_field("replacement", 32'(e.replacement), 32'(o_replacement));
                    check_field("evicted_tag", 32'(e.evicted), 32'(o_evicted_tag));
                end
            end
            i_stall <= receiver_stalls();
        end
    end

    initial begin : stimulus
        logic [dmwc_pkg::TAG_W-1:0] hot_tags [4];
        logic [dmwc_pkg::TAG_W-1:0] tg;
        for (int i = 0; i < LINES; i++) begin
            shadow_tag[i]   = '0;
            shadow_valid[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
        end

        // directed: cold miss, hits, dirty and clean evictions, extreme addresses
        add_ref(32'h0000_0000, 1'b0);   // invalid line, evicted tag zero
        add_ref(32'h0000_001F, 1'b0);   // hit, top offset
        add_ref(32'h0000_0004, 1'b1);   // write hit marks dirty
        add_ref(32'h0000_0010, 1'b0);   // read hit keeps dirty
        add_ref(32'h0000_1000, 1'b0);   // dirty miss: write-back and replacement
        add_ref(32'h0000_2000, 1'b0);   // clean miss: replacement only
        add_ref(32'h0000_2008, 1'b1);   // write hit
        add_ref(32'h0000_3000, 1'b1);   // dirty miss by a write, stays dirty
        add_ref(32'hFFFF_FFFF, 1'b1);   // all ones, cold line
        add_ref(32'hFFFF_FFE0, 1'b0);   // hit with top tag
        add_ref(32'h0000_0FE0, 1'b0);   // evicts top tag, dirty
        add_ref(32'h8000_0000, 1'b1);
        add_ref(32'h7FFF_FFFF, 1'b0);
        add_ref(32'hAAAA_AAAA, 1'b1);
        add_ref(32'h5555_5555, 1'b0);
        add_ref(32'h5555_5555, 1'b1);
        add_ref(32'hAAAA_AAAA, 1'b0);
        add_ref(32'h0001_0020, 1'b0);   // invalid line after reset

        // random: mostly a few recurring tags so lines hit, thrash and go dirty
        for (int i = 0; i < 4; i++) hot_tags[i] = dmwc_pkg::TAG_W'($urandom);
        for (int i = 0; i < RANDOM_REFS; i++) begin
            if ($urandom_range(99) < 10) begin
                add_ref($urandom, 1'($urandom_range(1)));
            end else begin
                tg = ($urandom_range(99) < 75) ? hot_tags[$urandom_range(3)]
                                               : dmwc_pkg::TAG_W'($urandom);
                add_ref({tg, 7'($urandom_range(LINES - 1)), 5'($urandom_range(31))},
                        1'($urandom_range(1)));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_refs.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_lookups.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d references checked: %0d hits, %0d misses", n_seen, n_hits, n_misses);
        $display("%0d write-backs, %0d replacements", n_wbacks, n_repls);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #2ms;
        $display("timeout after %0d items sent, %0d results seen", n_sent, n_seen);
        $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
